### rtl/core/lmc_pkg.sv
package lmc_pkg;

    // fixed field widths
    localparam int FW    = 20;
    localparam int CST_W = 31;
    localparam int RES_W = 33;

    localparam logic [CST_W-1:0] UNREACH    = 31'h7FFF_FFFF;
    localparam logic [31:0]      SORT_LIMIT = 32'd3000;

    // function codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_SOLVE = 2'd1;
    localparam logic [1:0] FUNC_FETCH = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOREC = 2'd2;
    localparam logic [1:0] ST_EXH   = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_FUDGE = 2'd1;
    localparam logic [1:0] CFG_FLEN  = 2'd2;
    localparam logic [1:0] CFG_SLEN  = 2'd3;

    // chain modes
    localparam logic [1:0] MODE_OVERLAP = 2'd0;

    // cost unit operations
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TAIL = 1'b1;

    typedef struct packed {
        logic op;
        logic place;
        logic tail_first;
    } t_cu_ctrl;

endpackage

### rtl/core/lmc_cost_unit.sv
module lmc_cost_unit (
    input  logic                           i_clk,
    input  lmc_pkg::t_cu_ctrl              i_ctrl,
    input  logic [lmc_pkg::FW-1:0]         i_fudge,
    input  logic [lmc_pkg::FW-1:0]         i_first_len,
    input  logic [lmc_pkg::FW-1:0]         i_second_len,
    input  logic [lmc_pkg::FW-1:0]         i_a_j,
    input  logic [lmc_pkg::FW-1:0]         i_b_j,
    input  logic [lmc_pkg::FW-1:0]         i_a_i,
    input  logic [lmc_pkg::FW-1:0]         i_b_i,
    input  logic [lmc_pkg::FW-1:0]         i_len_i,
    input  logic [lmc_pkg::CST_W-1:0]      i_cost_i,
    output logic signed [lmc_pkg::RES_W-1:0] o_res
);
    import lmc_pkg::*;

    logic [FW:0]                end_a;
    logic [FW:0]                end_b;
    logic signed [FW+1:0]       d1;
    logic signed [FW+1:0]       d2;
    logic [FW:0]                g1;
    logic [FW:0]                g2;
    logic                       far;
    logic [FW+1:0]              maxpen;
    logic [FW+2:0]              w;
    logic signed [FW+1:0]       tail;
    logic signed [FW+3:0]       n_s1;
    logic signed [FW+3:0]       r_s1;
    logic signed [RES_W-1:0]    sum;
    logic signed [RES_W-1:0]    n_res;
    logic signed [RES_W-1:0]    r_res;

    // stage 1: edge weight or tail term
    always_comb begin
        end_a  = {1'b0, i_a_i} + {1'b0, i_len_i};
        end_b  = {1'b0, i_b_i} + {1'b0, i_len_i};
        d1     = $signed({2'b00, i_a_j}) - $signed({1'b0, end_a});
        d2     = $signed({2'b00, i_b_j}) - $signed({1'b0, end_b});
        g1     = d1[FW+1] ? FW'(1'b0) + (FW+1)'(-d1) : d1[FW:0];
        g2     = d2[FW+1] ? FW'(1'b0) + (FW+1)'(-d2) : d2[FW:0];
        far    = (g1 > {1'b0, i_fudge}) || (g2 > {1'b0, i_fudge});
        maxpen = (FW+2)'(i_first_len) + (FW+2)'(i_second_len) + (FW+2)'(1);
        if (!i_ctrl.place && far) begin
            w = (FW+3)'(maxpen);
        end else begin
            w = (FW+3)'(g1) + (FW+3)'(g2);
        end
        if (i_ctrl.tail_first) begin
            tail = $signed({2'b00, i_first_len}) - $signed({1'b0, end_a});
        end else begin
            tail = $signed({2'b00, i_second_len}) - $signed({1'b0, end_b});
        end
        if (i_ctrl.op == OP_EDGE) begin
            n_s1 = $signed({1'b0, w});
        end else begin
            n_s1 = {{2{tail[FW+1]}}, tail};
        end
    end

    // stage 2: add to path cost, saturate in placement
    always_comb begin
        sum = $signed({2'b00, i_cost_i}) + $signed({{(RES_W-FW-4){r_s1[FW+3]}}, r_s1});
        if (i_ctrl.place && ((sum > $signed({2'b00, UNREACH}))
                || (i_ctrl.op == OP_TAIL && i_cost_i == UNREACH))) begin
            n_res = $signed({2'b00, UNREACH});
        end else begin
            n_res = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

### rtl/core/local_match_chaining_dp.sv
// channel | direction | handshake                  | word
// in      | input     | i_in_valid / o_in_ready    | i_func, i_start_a, i_start_b, i_match_len,
//         |           |                            | i_match_score
// out     | output    | o_out_valid / i_out_ready  | o_status .. o_last
// cfg     | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// load and clear go straight to S_OUT, fetch reads first (S_FT_RD, S_FT_DONE), then a word waits in the output register
// solve with n records runs a rank pass, the chaining pass and a tail pass, the last
// two through the one two-stage cost unit, all with one read port per memory, plus a
// walk over the predecessor links of the path records
// reset: synchronous active low, clears the store count, path and configuration
// a stalled output holds the result word; the next word is taken meanwhile
module local_match_chaining_dp #(
    parameter int MAX_RECORDS = 64,
    parameter int POS_BITS    = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_func,
    input  logic [lmc_pkg::FW-1:0]        i_start_a,
    input  logic [lmc_pkg::FW-1:0]        i_start_b,
    input  logic [lmc_pkg::FW-1:0]        i_match_len,
    input  logic [lmc_pkg::FW-1:0]        i_match_score,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [lmc_pkg::CST_W-1:0]     o_best_cost,
    output logic [6:0]                    o_count,
    output logic [lmc_pkg::FW-1:0]        o_out_start_a,
    output logic [lmc_pkg::FW-1:0]        o_out_start_b,
    output logic [lmc_pkg::FW-1:0]        o_out_len,
    output logic [lmc_pkg::FW-1:0]        o_out_score,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [lmc_pkg::FW-1:0]        i_cfg_data
);
    import lmc_pkg::*;

    localparam int PW    = (POS_BITS < FW) ? POS_BITS : FW;
    localparam int IW    = $clog2(MAX_RECORDS);
    localparam int CW    = $clog2(MAX_RECORDS + 1);
    localparam int REC_W = 2 * PW + 2 * FW;

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RK_RDJ  = 5'd1;
    localparam logic [4:0] S_RK_LDJ  = 5'd2;
    localparam logic [4:0] S_RK_RDI  = 5'd3;
    localparam logic [4:0] S_RK_CMP  = 5'd4;
    localparam logic [4:0] S_RK_WR   = 5'd5;
    localparam logic [4:0] S_DP_RDJ  = 5'd6;
    localparam logic [4:0] S_DP_LDJ  = 5'd7;
    localparam logic [4:0] S_DP_RDI  = 5'd8;
    localparam logic [4:0] S_DP_C1   = 5'd9;
    localparam logic [4:0] S_DP_C2   = 5'd10;
    localparam logic [4:0] S_DP_UPD  = 5'd11;
    localparam logic [4:0] S_DP_WR   = 5'd12;
    localparam logic [4:0] S_TL_RDI  = 5'd13;
    localparam logic [4:0] S_TL_C1   = 5'd14;
    localparam logic [4:0] S_TL_C2   = 5'd15;
    localparam logic [4:0] S_TL_CMP  = 5'd16;
    localparam logic [4:0] S_WK_RD   = 5'd17;
    localparam logic [4:0] S_WK_STEP = 5'd18;
    localparam logic [4:0] S_FT_RD   = 5'd19;
    localparam logic [4:0] S_FT_DONE = 5'd20;
    localparam logic [4:0] S_OUT     = 5'd21;

    // record layout: start_a, start_b, length, score
    function automatic logic [PW-1:0] rec_a(input logic [REC_W-1:0] rec);
        rec_a = rec[REC_W-1 -: PW];
    endfunction

    function automatic logic [PW-1:0] rec_b(input logic [REC_W-1:0] rec);
        rec_b = rec[2*FW+PW-1 -: PW];
    endfunction

    function automatic logic [PW-1:0] sort_key(input logic [REC_W-1:0] rec,
                                               input logic             by_a);
        sort_key = by_a ? rec_a(rec) : rec_b(rec);
    endfunction

    // control
    logic [4:0]       r_state,     n_state;
    logic [CW-1:0]    r_count,     n_count;
    logic             r_cur_v,     n_cur_v;
    logic [CW-1:0]    r_total,     n_total;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_mode,      n_mode;
    logic [FW-1:0]    r_fudge,     n_fudge;
    logic [FW-1:0]    r_flen,      n_flen;
    logic [FW-1:0]    r_slen,      n_slen;

    // sequencer data
    logic [IW-1:0]    r_cursor,    n_cursor;
    logic [IW-1:0]    r_j,         n_j;
    logic [IW-1:0]    r_i,         n_i;
    logic [IW-1:0]    r_rank,      n_rank;
    logic [REC_W-1:0] r_rec_j,     n_rec_j;
    logic [CST_W-1:0] r_cost_j,    n_cost_j;
    logic [IW-1:0]    r_pred,      n_pred;
    logic             r_pred_v,    n_pred_v;
    logic [IW-1:0]    r_best,      n_best;
    logic signed [RES_W-1:0] r_best_cost, n_best_cost;
    logic [CW-1:0]    r_walk,      n_walk;

    // pending result word
    logic [1:0]       r_p_status,  n_p_status;
    logic [CST_W-1:0] r_p_cost,    n_p_cost;
    logic [6:0]       r_p_count,   n_p_count;
    logic [FW-1:0]    r_p_a,       n_p_a;
    logic [FW-1:0]    r_p_b,       n_p_b;
    logic [FW-1:0]    r_p_len,     n_p_len;
    logic [FW-1:0]    r_p_score,   n_p_score;
    logic             r_p_last,    n_p_last;

    // output register
    logic [1:0]       r_o_status,  n_o_status;
    logic [CST_W-1:0] r_o_cost,    n_o_cost;
    logic [6:0]       r_o_count,   n_o_count;
    logic [FW-1:0]    r_o_a,       n_o_a;
    logic [FW-1:0]    r_o_b,       n_o_b;
    logic [FW-1:0]    r_o_len,     n_o_len;
    logic [FW-1:0]    r_o_score,   n_o_score;
    logic             r_o_last,    n_o_last;

    // memories: load-order store, sorted copy, path cost, predecessor link
    logic [REC_W-1:0] r_rec_mem  [MAX_RECORDS];
    logic [REC_W-1:0] r_srec_mem [MAX_RECORDS];
    logic [CST_W-1:0] r_cost_mem [MAX_RECORDS];
    logic [IW:0]      r_pred_mem [MAX_RECORDS];
    logic [REC_W-1:0] r_rec_q;
    logic [REC_W-1:0] r_srec_q;
    logic [CST_W-1:0] r_cost_q;
    logic [IW:0]      r_pred_q;

    logic             in_acc;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             rec_we;
    logic             srec_we;
    logic             dp_we;
    logic [REC_W-1:0] load_rec;
    logic             place;
    logic             tie_first;
    logic             new_best;
    logic [CST_W-1:0] best_clamp;
    logic [CST_W-1:0] init_cost;
    t_cu_ctrl         cu_ctrl;
    logic signed [RES_W-1:0] cu_res;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign place      = r_mode[1];
    assign load_rec   = {i_start_a[PW-1:0], i_start_b[PW-1:0], i_match_len, i_match_score};
    assign rec_we     = in_acc && (i_func == FUNC_LOAD) && (r_count < CW'(MAX_RECORDS));
    assign srec_we    = (r_state == S_RK_WR);
    assign dp_we      = (r_state == S_DP_WR);

    // stable sort: earlier load wins ties
    assign tie_first = (sort_key(r_rec_q, place) < sort_key(r_rec_j, place))
                    || ((sort_key(r_rec_q, place) == sort_key(r_rec_j, place)) && (r_i < r_j));

    // first minimum of the tail-added costs
    assign new_best = (r_i == '0) || (cu_res < r_best_cost);

    // placement chains start only at start_a zero
    assign init_cost = place ? ((rec_a(r_srec_q) == '0) ? '0 : UNREACH)
                             : CST_W'(rec_b(r_srec_q));

    always_comb begin
        if (r_best_cost[RES_W-1]) begin
            best_clamp = '0;
        end else if (r_best_cost > $signed({2'b00, UNREACH})) begin
            best_clamp = UNREACH;
        end else begin
            best_clamp = r_best_cost[CST_W-1:0];
        end
    end

    always_comb begin
        cu_ctrl.op         = (r_state inside {S_TL_RDI, S_TL_C1, S_TL_C2, S_TL_CMP})
                             ? OP_TAIL : OP_EDGE;
        cu_ctrl.place      = place;
        cu_ctrl.tail_first = (r_mode == MODE_OVERLAP);
    end

    lmc_cost_unit u_cost (
        .i_clk        (i_clk),
        .i_ctrl       (cu_ctrl),
        .i_fudge      (r_fudge),
        .i_first_len  (r_flen),
        .i_second_len (r_slen),
        .i_a_j        (FW'(rec_a(r_rec_j))),
        .i_b_j        (FW'(rec_b(r_rec_j))),
        .i_a_i        (FW'(rec_a(r_srec_q))),
        .i_b_i        (FW'(rec_b(r_srec_q))),
        .i_len_i      (r_srec_q[2*FW-1 -: FW]),
        .i_cost_i     (r_cost_q),
        .o_res        (cu_res)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cur_v     = r_cur_v;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_mode      = r_mode;
        n_fudge     = r_fudge;
        n_flen      = r_flen;
        n_slen      = r_slen;
        n_cursor    = r_cursor;
        n_j         = r_j;
        n_i         = r_i;
        n_rank      = r_rank;
        n_rec_j     = r_rec_j;
        n_cost_j    = r_cost_j;
        n_pred      = r_pred;
        n_pred_v    = r_pred_v;
        n_best      = r_best;
        n_best_cost = r_best_cost;
        n_walk      = r_walk;
        n_p_status  = r_p_status;
        n_p_cost    = r_p_cost;
        n_p_count   = r_p_count;
        n_p_a       = r_p_a;
        n_p_b       = r_p_b;
        n_p_len     = r_p_len;
        n_p_score   = r_p_score;
        n_p_last    = r_p_last;
        n_o_status  = r_o_status;
        n_o_cost    = r_o_cost;
        n_o_count   = r_o_count;
        n_o_a       = r_o_a;
        n_o_b       = r_o_b;
        n_o_len     = r_o_len;
        n_o_score   = r_o_score;
        n_o_last    = r_o_last;
        rd_en       = 1'b0;
        rd_addr     = r_i;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:  n_mode  = i_cfg_data[1:0];
                CFG_FUDGE: n_fudge = i_cfg_data;
                CFG_FLEN:  n_flen  = i_cfg_data;
                CFG_SLEN:  n_slen  = i_cfg_data;
                default:   n_mode  = r_mode;
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_p_status = ST_OK;
                    n_p_cost   = '0;
                    n_p_count  = '0;
                    n_p_a      = '0;
                    n_p_b      = '0;
                    n_p_len    = '0;
                    n_p_score  = '0;
                    n_p_last   = 1'b0;
                    n_state    = S_OUT;
                    case (i_func)
                        FUNC_LOAD: begin
                            n_cur_v = 1'b0;
                            n_total = '0;
                            if (r_count < CW'(MAX_RECORDS)) begin
                                n_count = r_count + CW'(1);
                            end else begin
                                n_p_status = ST_FULL;
                            end
                            n_p_count = 7'(n_count);
                        end
                        FUNC_SOLVE: begin
                            n_cur_v = 1'b0;
                            n_total = '0;
                            if ((r_count == '0)
                                    || ((r_mode != MODE_OVERLAP)
                                        && (32'(r_count) > SORT_LIMIT))) begin
                                n_p_status = ST_NOREC;
                            end else begin
                                n_j     = '0;
                                n_state = S_RK_RDJ;
                            end
                        end
                        FUNC_FETCH: begin
                            if (!r_cur_v || (CW'(r_cursor) >= r_count)) begin
                                n_cur_v    = 1'b0;
                                n_p_status = ST_EXH;
                                n_p_count  = 7'(r_total);
                            end else begin
                                n_state = S_FT_RD;
                            end
                        end
                        default: begin
                            n_count = '0;
                            n_cur_v = 1'b0;
                            n_total = '0;
                        end
                    endcase
                end
            end
            // rank pass: position of record j in the sorted order
            S_RK_RDJ: begin
                rd_en   = 1'b1;
                rd_addr = r_j;
                n_state = S_RK_LDJ;
            end
            S_RK_LDJ: begin
                n_rec_j = r_rec_q;
                n_i     = '0;
                n_rank  = '0;
                n_state = S_RK_RDI;
            end
            S_RK_RDI: begin
                rd_en   = 1'b1;
                n_state = S_RK_CMP;
            end
            S_RK_CMP: begin
                if (tie_first) begin
                    n_rank = r_rank + IW'(1);
                end
                if (CW'(r_i) + CW'(1) == r_count) begin
                    n_state = S_RK_WR;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_RK_RDI;
                end
            end
            S_RK_WR: begin
                if (CW'(r_j) + CW'(1) == r_count) begin
                    n_j     = '0;
                    n_state = S_DP_RDJ;
                end else begin
                    n_j     = r_j + IW'(1);
                    n_state = S_RK_RDJ;
                end
            end
            // chaining pass over sorted records
            S_DP_RDJ: begin
                rd_en   = 1'b1;
                rd_addr = r_j;
                n_state = S_DP_LDJ;
            end
            S_DP_LDJ: begin
                n_rec_j  = r_srec_q;
                n_cost_j = init_cost;
                n_pred_v = 1'b0;
                n_pred   = '0;
                n_i      = '0;
                n_state  = (r_j == '0) ? S_DP_WR : S_DP_RDI;
            end
            S_DP_RDI: begin
                rd_en   = 1'b1;
                n_state = S_DP_C1;
            end
            S_DP_C1: n_state = S_DP_C2;
            S_DP_C2: n_state = S_DP_UPD;
            S_DP_UPD: begin
                // latest equal candidate wins
                if ($signed({2'b00, r_cost_j}) >= cu_res) begin
                    n_cost_j = cu_res[CST_W-1:0];
                    n_pred   = r_i;
                    n_pred_v = 1'b1;
                end
                if (r_i + IW'(1) == r_j) begin
                    n_state = S_DP_WR;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_DP_RDI;
                end
            end
            S_DP_WR: begin
                if (CW'(r_j) + CW'(1) == r_count) begin
                    n_i     = '0;
                    n_state = S_TL_RDI;
                end else begin
                    n_j     = r_j + IW'(1);
                    n_state = S_DP_RDJ;
                end
            end
            // tail pass and best pick
            S_TL_RDI: begin
                rd_en   = 1'b1;
                n_state = S_TL_C1;
            end
            S_TL_C1: n_state = S_TL_C2;
            S_TL_C2: n_state = S_TL_CMP;
            S_TL_CMP: begin
                if (new_best) begin
                    n_best      = r_i;
                    n_best_cost = cu_res;
                end
                if (CW'(r_i) + CW'(1) == r_count) begin
                    n_i     = new_best ? r_i : r_best;
                    n_walk  = '0;
                    n_state = S_WK_RD;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_TL_RDI;
                end
            end
            // path length walk over predecessor links
            S_WK_RD: begin
                rd_en   = 1'b1;
                n_state = S_WK_STEP;
            end
            S_WK_STEP: begin
                n_walk = r_walk + CW'(1);
                if (r_pred_q[IW]) begin
                    n_i     = r_pred_q[IW-1:0];
                    n_state = S_WK_RD;
                end else begin
                    n_cur_v    = 1'b1;
                    n_cursor   = r_best;
                    n_total    = r_walk + CW'(1);
                    n_p_status = ST_OK;
                    n_p_cost   = best_clamp;
                    n_p_count  = 7'(r_walk + CW'(1));
                    n_state    = S_OUT;
                end
            end
            S_FT_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_cursor;
                n_state = S_FT_DONE;
            end
            S_FT_DONE: begin
                n_p_status = ST_OK;
                n_p_count  = 7'(r_total);
                n_p_a      = FW'(rec_a(r_srec_q));
                n_p_b      = FW'(rec_b(r_srec_q));
                n_p_len    = r_srec_q[2*FW-1 -: FW];
                n_p_score  = r_srec_q[FW-1:0];
                n_p_last   = !r_pred_q[IW];
                n_cur_v    = r_pred_q[IW];
                n_cursor   = r_pred_q[IW-1:0];
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_p_status;
                    n_o_cost    = r_p_cost;
                    n_o_count   = r_p_count;
                    n_o_a       = r_p_a;
                    n_o_b       = r_p_b;
                    n_o_len     = r_p_len;
                    n_o_score   = r_p_score;
                    n_o_last    = r_p_last;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur_v     <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_OVERLAP;
            r_fudge     <= FW'(30);
            r_flen      <= '0;
            r_slen      <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur_v     <= n_cur_v;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            r_mode      <= n_mode;
            r_fudge     <= n_fudge;
            r_flen      <= n_flen;
            r_slen      <= n_slen;
        end
    end

    // data registers
    always_ff @(posedge i_clk) begin
        r_cursor    <= n_cursor;
        r_j         <= n_j;
        r_i         <= n_i;
        r_rank      <= n_rank;
        r_rec_j     <= n_rec_j;
        r_cost_j    <= n_cost_j;
        r_pred      <= n_pred;
        r_pred_v    <= n_pred_v;
        r_best      <= n_best;
        r_best_cost <= n_best_cost;
        r_walk      <= n_walk;
        r_p_status  <= n_p_status;
        r_p_cost    <= n_p_cost;
        r_p_count   <= n_p_count;
        r_p_a       <= n_p_a;
        r_p_b       <= n_p_b;
        r_p_len     <= n_p_len;
        r_p_score   <= n_p_score;
        r_p_last    <= n_p_last;
        r_o_status  <= n_o_status;
        r_o_cost    <= n_o_cost;
        r_o_count   <= n_o_count;
        r_o_a       <= n_o_a;
        r_o_b       <= n_o_b;
        r_o_len     <= n_o_len;
        r_o_score   <= n_o_score;
        r_o_last    <= n_o_last;
    end

    // memories, one shared read address, registered read data
    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_rec_mem[r_count[IW-1:0]] <= load_rec;
        end
        if (srec_we) begin
            r_srec_mem[r_rank] <= r_rec_j;
        end
        if (dp_we) begin
            r_cost_mem[r_j] <= r_cost_j;
            r_pred_mem[r_j] <= {r_pred_v, r_pred};
        end
        if (rd_en) begin
            r_rec_q  <= r_rec_mem[rd_addr];
            r_srec_q <= r_srec_mem[rd_addr];
            r_cost_q <= r_cost_mem[rd_addr];
            r_pred_q <= r_pred_mem[rd_addr];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_best_cost   = r_o_cost;
    assign o_count       = r_o_count;
    assign o_out_start_a = r_o_a;
    assign o_out_start_b = r_o_b;
    assign o_out_len     = r_o_len;
    assign o_out_score   = r_o_score;
    assign o_last        = r_o_last;

    // store never grows past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RECORDS))
        else $error("record count beyond store depth");

    // an accepted word blocks the input in the cycle after it
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input ready right after accept");

    // a dropped load reports a full store
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_count == 7'(MAX_RECORDS)))
        else $error("full status with store not full");

    // a live path always has a nonzero length
    a_path_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_v |-> (r_total != '0))
        else $error("path cursor live with empty path");

endmodule
